// ===== hdl/vpfc_pkg.sv =====
// ============================================================================
// vpfc_pkg: shared types and constants for the video playback frame clock
// Command codes, play states, register indexes and the control/status
// structs passed between controller and datapath.
// ============================================================================
`default_nettype none

package vpfc_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int FRAC_BITS_DEF = 8;

    localparam int CMD_W   = 3;
    localparam int STATE_W = 2;
    localparam int DUR_W   = 24;
    localparam int FPL_W   = 32;
    localparam int LOOPS_W = 17;
    localparam int FRAME_W = 32;
    localparam int LOOP_W  = 31;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 32;

    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    localparam logic [STATE_W-1:0] PS_STOPPED  = 2'd0;
    localparam logic [STATE_W-1:0] PS_PLAYING  = 2'd1;
    localparam logic [STATE_W-1:0] PS_PAUSED   = 2'd2;
    localparam logic [STATE_W-1:0] PS_FINISHED = 2'd3;

    localparam logic [IDX_W-1:0] REG_FRAME_DUR   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAMES_LOOP = 2'd1;
    localparam logic [IDX_W-1:0] REG_PLAY_LOOPS  = 2'd2;

    localparam logic [DUR_W-1:0]   DUR_RESET   = 24'd12800;
    localparam logic [LOOPS_W-1:0] LOOPS_RESET = 17'd1;
    localparam int                 DEFAULT_DUR_MS = 50;
    localparam logic [LOOP_W-1:0]  LOOP_MAX    = 31'h7FFF_FFFF;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load2;
        logic mul;
        logic update;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic tick_go;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/vpfc_ctrl.sv =====
// ============================================================================
// vpfc_ctrl: sequencing state machine
// Accepts one command, steps the shared divider twice for a tick, then
// hands the result to the output register.
// ============================================================================
`default_nettype none

module vpfc_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  vpfc_pkg::dp_stat_t    stat,
    output vpfc_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.tick_go ? S_DIV1 : S_FIN;
                end
            end
            S_DIV1:
            begin
                if (!stat.div_done)
                    cmd.div_step = 1'b1;
                else
                begin
                    cmd.load2  = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (!stat.div_done)
                    cmd.div_step = 1'b1;
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/vpfc_dp.sv =====
// ============================================================================
// vpfc_dp: playback clock datapath
// Holds configuration, play state, the shared restoring divider, the
// loop-time multiplier and the output register.
// ============================================================================
`default_nettype none

module vpfc_dp
#(
    parameter int TIME_BITS = vpfc_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = vpfc_pkg::FRAC_BITS_DEF,
    parameter int IN_W      = 48,
    parameter int OUT_W     = 152
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [vpfc_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [vpfc_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic [IN_W-1:0]               s_tdata,
    input  wire logic [vpfc_pkg::CMD_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [OUT_W-1:0]                   m_tdata,
    input  vpfc_pkg::dp_cmd_t                  cmd,
    output vpfc_pkg::dp_stat_t                 stat
);

    localparam int QW    = TIME_BITS + FRAC_BITS;
    localparam int DW    = vpfc_pkg::FPL_W;
    localparam int CW    = $clog2(QW + 1);
    localparam int PW    = DW + vpfc_pkg::DUR_W;
    localparam int SW    = TIME_BITS + FRAC_BITS + DW;
    localparam int RAW_W = 100 + TIME_BITS;
    localparam logic [vpfc_pkg::DUR_W-1:0] DEN_DEFAULT =
        vpfc_pkg::DUR_W'(vpfc_pkg::DEFAULT_DUR_MS) << FRAC_BITS;
    localparam logic [TIME_BITS-1:0] TMASK = '1;

    // configuration
    logic [vpfc_pkg::DUR_W-1:0]   dur_reg;
    logic [vpfc_pkg::FPL_W-1:0]   fpl_reg;
    logic [vpfc_pkg::LOOPS_W-1:0] loops_reg;

    // playback state
    logic [vpfc_pkg::STATE_W-1:0] ps_reg;
    logic [TIME_BITS-1:0]         start_reg;
    logic [TIME_BITS-1:0]         pst_reg;
    logic [TIME_BITS-1:0]         tp_reg;
    logic [vpfc_pkg::FRAME_W-1:0] shown_reg;
    logic [vpfc_pkg::LOOP_W-1:0]  loop_reg;
    logic [vpfc_pkg::FRAME_W-1:0] skip_reg;

    // divider and multiplier
    logic [QW-1:0]                dq_reg;
    logic [DW-1:0]                rem_reg;
    logic [DW-1:0]                div_reg;
    logic [CW-1:0]                cnt_reg;
    logic [vpfc_pkg::DUR_W-1:0]   den_reg;
    logic [vpfc_pkg::DUR_W-1:0]   rem1_reg;
    logic [PW-1:0]                prod_reg;

    // tick results
    logic                         chg_reg;
    logic                         lchg_reg;
    logic                         fin_reg;
    logic [vpfc_pkg::FRAME_W-1:0] fidx_reg;
    logic [vpfc_pkg::LOOP_W-1:0]  lnum_reg;
    logic [TIME_BITS-1:0]         lel_reg;

    logic                         out_valid_reg;
    logic [OUT_W-1:0]             out_data_reg;

    logic [TIME_BITS-1:0]         now;
    logic [TIME_BITS-1:0]         since_start;
    logic [TIME_BITS-1:0]         elapsed;
    logic [TIME_BITS-1:0]         pause_d;
    logic [vpfc_pkg::DUR_W-1:0]   den;
    logic [DW:0]                  rem_sh;
    logic                         rem_ge;
    logic [DW:0]                  rem_sub;
    logic                         endless;
    logic [15:0]                  nloops;
    logic                         done_all;
    logic [vpfc_pkg::LOOP_W-1:0]  loop_new;
    logic [vpfc_pkg::FRAME_W-1:0] shown_inc;
    logic [SW-1:0]                lel_sum;
    logic [RAW_W-1:0]             out_raw;

    assign now         = s_tdata[TIME_BITS-1:0];
    assign since_start = now - start_reg;
    assign elapsed     = (now > start_reg && since_start > tp_reg) ? since_start - tp_reg : '0;
    assign pause_d     = (now > pst_reg) ? now - pst_reg : '0;
    assign den         = (dur_reg != '0) ? dur_reg : DEN_DEFAULT;

    assign rem_sh  = {rem_reg, dq_reg[QW-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign rem_ge  = rem_sh >= {1'b0, div_reg};

    assign endless   = (loops_reg == '1);
    assign nloops    = (loops_reg[16] || loops_reg[15:0] == '0) ? 16'd1 : loops_reg[15:0];
    assign done_all  = !endless && (dq_reg >= QW'(nloops));
    assign loop_new  = (dq_reg >= QW'(vpfc_pkg::LOOP_MAX)) ? vpfc_pkg::LOOP_MAX
                                                           : dq_reg[30:0] + 31'd1;
    assign shown_inc = shown_reg + 32'd1;
    assign lel_sum   = SW'(prod_reg) + SW'(rem1_reg);

    assign stat.tick_go  = (s_tuser == vpfc_pkg::CMD_TICK)
                        && (ps_reg == vpfc_pkg::PS_PLAYING) && (fpl_reg != '0);
    assign stat.div_done = (cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign out_raw = {skip_reg, lel_reg, lnum_reg, fidx_reg, fin_reg, lchg_reg, chg_reg, ps_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg       <= vpfc_pkg::DUR_RESET;
            fpl_reg       <= '0;
            loops_reg     <= vpfc_pkg::LOOPS_RESET;
            ps_reg        <= vpfc_pkg::PS_STOPPED;
            start_reg     <= '0;
            pst_reg       <= '0;
            tp_reg        <= '0;
            shown_reg     <= '0;
            loop_reg      <= 31'd1;
            skip_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    vpfc_pkg::REG_FRAME_DUR:   dur_reg   <= cfg_data[vpfc_pkg::DUR_W-1:0];
                    vpfc_pkg::REG_FRAMES_LOOP: fpl_reg   <= cfg_data;
                    vpfc_pkg::REG_PLAY_LOOPS:  loops_reg <= cfg_data[vpfc_pkg::LOOPS_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.accept)
            begin
                case (s_tuser)
                    vpfc_pkg::CMD_START:
                    begin
                        ps_reg    <= vpfc_pkg::PS_PLAYING;
                        start_reg <= now;
                        pst_reg   <= '0;
                        tp_reg    <= '0;
                        shown_reg <= '0;
                        loop_reg  <= 31'd1;
                        skip_reg  <= '0;
                    end
                    vpfc_pkg::CMD_STOP:
                        ps_reg <= vpfc_pkg::PS_STOPPED;
                    vpfc_pkg::CMD_PAUSE:
                        if (ps_reg == vpfc_pkg::PS_PLAYING)
                        begin
                            ps_reg  <= vpfc_pkg::PS_PAUSED;
                            pst_reg <= now;
                        end
                    vpfc_pkg::CMD_RESUME:
                        if (ps_reg == vpfc_pkg::PS_PAUSED)
                        begin
                            // saturate the pause total
                            tp_reg  <= (pause_d > (TMASK - tp_reg)) ? TMASK : tp_reg + pause_d;
                            pst_reg <= '0;
                            ps_reg  <= vpfc_pkg::PS_PLAYING;
                        end
                    default: ;
                endcase
                if (stat.tick_go)
                    cnt_reg <= CW'(QW);
            end
            else if (cmd.load2)
                cnt_reg <= CW'(QW);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - CW'(1);

            if (cmd.update)
            begin
                if (done_all)
                    ps_reg <= vpfc_pkg::PS_FINISHED;
                else
                begin
                    loop_reg <= loop_new;
                    if (rem_reg > shown_inc)
                        skip_reg <= skip_reg + rem_reg - shown_inc;
                    if (rem_reg != shown_reg || loop_new != loop_reg)
                        shown_reg <= rem_reg;
                end
            end

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // divider, multiplier and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            chg_reg  <= 1'b0;
            lchg_reg <= 1'b0;
            fin_reg  <= 1'b0;
            fidx_reg <= '0;
            lnum_reg <= '0;
            lel_reg  <= '0;
            dq_reg   <= QW'(elapsed) << FRAC_BITS;
            rem_reg  <= '0;
            div_reg  <= DW'(den);
            den_reg  <= den;
        end
        else if (cmd.load2)
        begin
            rem1_reg <= rem_reg[vpfc_pkg::DUR_W-1:0];
            rem_reg  <= '0;
            div_reg  <= fpl_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            dq_reg  <= {dq_reg[QW-2:0], rem_ge};
        end

        if (cmd.mul)
            prod_reg <= rem_reg * den_reg;

        if (cmd.update)
        begin
            if (done_all)
            begin
                chg_reg  <= 1'b1;
                fin_reg  <= 1'b1;
                fidx_reg <= fpl_reg - 32'd1;
                lnum_reg <= 31'(nloops);
            end
            else
            begin
                lchg_reg <= (loop_new != loop_reg);
                lnum_reg <= loop_new;
                lel_reg  <= lel_sum[FRAC_BITS +: TIME_BITS];
                if (rem_reg != shown_reg || loop_new != loop_reg)
                begin
                    chg_reg  <= 1'b1;
                    fidx_reg <= rem_reg;
                end
            end
        end

        if (cmd.load_out)
            out_data_reg <= OUT_W'(out_raw);
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QW))
        else $error("divider count out of range");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");

    a_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && done_all) |=> (ps_reg == vpfc_pkg::PS_FINISHED))
        else $error("finish did not set finished state");

    a_fin_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[4]) |-> (out_data_reg[2] && !out_data_reg[3]))
        else $error("finished result with wrong change flags");
`endif

endmodule

`default_nettype wire

// ===== hdl/video_playback_frame_clock.sv =====
// ============================================================================
// video_playback_frame_clock: playback clock for one video stream
// Timestamped start/stop/pause/resume/tick commands in, one status item out.
// ============================================================================
//   s_*: one command per transfer; tuser carries the command code, tdata the
//   timestamp in ms. m_*: one result per command. cfg_*: register index and
//   data, always ready; write only while the block is idle.
//   Sequence: start, stop, pause, resume, unknown codes and ticks that do not
//   run go straight to the output load step. A running tick takes two passes
//   of the shared one-bit-per-cycle divider with a reload step between them,
//   then one multiply, one update and one output load step.
//   Flow: one command at a time, s_tready high only while idle.
//   Stall: a result waits in the output register while the next command is
//   accepted and processed; that one holds in the final step, s_tready low.
//   Reset: asynchronous, active low; clears play state and counters and sets
//   the registers to their defaults (50 ms frames, no frames, one loop).
// ============================================================================
`default_nettype none

module video_playback_frame_clock
#(
    parameter int TIME_BITS = vpfc_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = vpfc_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [vpfc_pkg::IDX_W-1:0]            cfg_index,
    input  wire logic [vpfc_pkg::CFG_W-1:0]            cfg_data,
    // command stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((TIME_BITS+7)/8)*8-1:0]        s_tdata,  // timestamp_ms, zero pad
    input  wire logic [vpfc_pkg::CMD_W-1:0]            s_tuser,  // cmd
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // play_status, new frame flag, new loop flag, finished, frame_index,
    // loop_number, time within the loop in ms, skipped_count, zero pad
    output logic [((100+TIME_BITS+7)/8)*8-1:0]         m_tdata
);

    localparam int IN_W  = ((TIME_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((100 + TIME_BITS + 7) / 8) * 8;

    vpfc_pkg::dp_cmd_t  dp_cmd;
    vpfc_pkg::dp_stat_t dp_stat;

    // registers are taken in any cycle
    assign cfg_ready = 1'b1;

    vpfc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    vpfc_dp
    #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (IN_W),
        .OUT_W     (OUT_W)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

endmodule

`default_nettype wire

// ===== tb/video_playback_frame_clock_tb.sv =====
// ============================================================================
// video_playback_frame_clock_tb: self-checking bench for the playback clock
// Feeds timestamped start/stop/pause/resume/tick commands with random gaps,
// predicts each status item from its own model of the play state and the
// frame arithmetic, and checks every result field by field in order.
// ============================================================================
`default_nettype none

module video_playback_frame_clock_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = 48;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};
    localparam int DW = 152;

    // one command as offered on the slave stream
    typedef struct packed {
        logic [vpfc_pkg::CMD_W-1:0] cmd;
        logic [TW-1:0]              ts;
    } command_t;

    // one status item as returned on the master stream
    typedef struct packed {
        logic [1:0]                   status;
        logic                         frame_chg;
        logic                         loop_chg;
        logic                         fin;
        logic [vpfc_pkg::FRAME_W-1:0] frame_num;
        logic [vpfc_pkg::LOOP_W-1:0]  loop_num;
        logic [TW-1:0]                loop_ms;
        logic [31:0]                  skipped;
    } status_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [vpfc_pkg::IDX_W-1:0]   cfg_index;
    logic [vpfc_pkg::CFG_W-1:0]   cfg_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [TW-1:0]                s_tdata;
    logic [vpfc_pkg::CMD_W-1:0]   s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [DW-1:0]                m_tdata;

    video_playback_frame_clock dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // bench-side copy of the registers and the play state
    logic [vpfc_pkg::DUR_W-1:0]   dur_q8;
    logic [vpfc_pkg::FPL_W-1:0]   frames_loop;
    logic [vpfc_pkg::LOOPS_W-1:0] loops_cfg;
    logic [1:0]                   play_st;
    logic [TW-1:0]                t_start;
    logic [TW-1:0]                t_pause;
    logic [TW-1:0]                paused_total;
    logic [31:0]                  cur_frame;
    logic [vpfc_pkg::LOOP_W-1:0]  cur_loop;
    logic [31:0]                  skip_total;

    command_t pending_cmds[$];
    status_t  status_due[$];
    logic     cmd_fire;
    bit       no_gaps;
    bit       failed;
    int       tx_gap;
    int       rx_wait;
    int       hold_cnt;
    int       hold_go;
    int       hold_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop well beyond the slowest legitimate run
    initial
    begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none while no_gaps holds.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Advance the play state by one command and return its status item.
    function automatic status_t play_step(command_t c);
        status_t       o;
        logic [TW-1:0] d;
        logic [TW-1:0] elapsed;
        logic [63:0]   den;
        logic [63:0]   num;
        logic [63:0]   absf;
        logic [63:0]   rem;
        logic [63:0]   lidx;
        logic [63:0]   fil;
        logic [63:0]   nloops;
        logic [63:0]   lel;
        logic [vpfc_pkg::LOOP_W-1:0] prev;
        logic [31:0]   want;
        bit            endless;
        o = '0;
        case (c.cmd)
            vpfc_pkg::CMD_START:
            begin
                play_st      = vpfc_pkg::PS_PLAYING;
                t_start      = c.ts;
                t_pause      = '0;
                paused_total = '0;
                cur_frame    = '0;
                cur_loop     = vpfc_pkg::LOOP_W'(1);
                skip_total   = '0;
            end
            vpfc_pkg::CMD_STOP:
                play_st = vpfc_pkg::PS_STOPPED;
            vpfc_pkg::CMD_PAUSE:
                if (play_st == vpfc_pkg::PS_PLAYING)
                begin
                    play_st = vpfc_pkg::PS_PAUSED;
                    t_pause = c.ts;
                end
            vpfc_pkg::CMD_RESUME:
                if (play_st == vpfc_pkg::PS_PAUSED)
                begin
                    d = (c.ts > t_pause) ? c.ts - t_pause : '0;
                    // saturate the pause total rather than wrap
                    if (d > TMAX - paused_total)
                        paused_total = TMAX;
                    else
                        paused_total = paused_total + d;
                    t_pause = '0;
                    play_st = vpfc_pkg::PS_PLAYING;
                end
            vpfc_pkg::CMD_TICK:
                if (play_st == vpfc_pkg::PS_PLAYING && frames_loop != 0)
                begin
                    elapsed = '0;
                    if (c.ts > t_start)
                    begin
                        d = c.ts - t_start;
                        elapsed = (d > paused_total) ? d - paused_total : '0;
                    end
                    den  = (dur_q8 != 0) ? 64'(dur_q8)
                                         : 64'(vpfc_pkg::DEFAULT_DUR_MS) << 8;
                    num  = 64'(elapsed) << 8;
                    absf = num / den;
                    rem  = num % den;
                    lidx = absf / 64'(frames_loop);
                    fil  = absf % 64'(frames_loop);
                    endless = (loops_cfg == '1);
                    nloops  = (!loops_cfg[16] && loops_cfg != 0) ? 64'(loops_cfg) : 64'd1;
                    prev    = cur_loop;
                    if (!endless && lidx >= nloops)
                    begin
                        play_st     = vpfc_pkg::PS_FINISHED;
                        o.frame_chg = 1'b1;
                        o.fin       = 1'b1;
                        o.frame_num = frames_loop - 32'd1;
                        o.loop_num  = vpfc_pkg::LOOP_W'(nloops);
                    end
                    else
                    begin
                        cur_loop   = (lidx >= 64'(vpfc_pkg::LOOP_MAX))
                                   ? vpfc_pkg::LOOP_MAX : vpfc_pkg::LOOP_W'(lidx + 1);
                        want       = 32'(fil);
                        o.loop_chg = (cur_loop != prev);
                        o.loop_num = cur_loop;
                        lel        = (fil * den + rem) >> 8;
                        o.loop_ms  = lel[TW-1:0];
                        if (want > 32'(cur_frame + 32'd1))
                            skip_total = skip_total + want - cur_frame - 32'd1;
                        if (want != cur_frame || o.loop_chg)
                        begin
                            cur_frame   = want;
                            o.frame_chg = 1'b1;
                            o.frame_num = want;
                        end
                    end
                end
            default: ;
        endcase
        o.status  = play_st;
        o.skipped = skip_total;
        return o;
    endfunction

    // Sender: hold an offered command until its transfer, then advance.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap   = 0;
        end
        else if (s_tvalid && !cmd_fire)
            ;
        else if (tx_gap > 0)
        begin
            s_tvalid <= 1'b0;
            tx_gap--;
        end
        else if (pending_cmds.size() != 0)
        begin
            command_t c;
            c = pending_cmds.pop_front();
            s_tuser  <= c.cmd;
            s_tdata  <= c.ts;
            s_tvalid <= 1'b1;
            tx_gap   = pick_gap();
        end
        else
            s_tvalid <= 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_wait   = 0;
            hold_cnt  = 0;
            hold_done = 0;
        end
        else
        begin
            if (hold_done != hold_go)
            begin
                hold_done = hold_go;
                hold_cnt  = 600;
            end
            if (hold_cnt > 0)
            begin
                m_tready <= 1'b0;
                hold_cnt--;
            end
            else if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_wait = pick_gap();
            end
        end
    end

    // Monitor: track register writes, predict on command transfers and
    // check each result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_fire     <= 1'b0;
            dur_q8       = vpfc_pkg::DUR_RESET;
            frames_loop  = '0;
            loops_cfg    = vpfc_pkg::LOOPS_RESET;
            play_st      = vpfc_pkg::PS_STOPPED;
            t_start      = '0;
            t_pause      = '0;
            paused_total = '0;
            cur_frame    = '0;
            cur_loop     = vpfc_pkg::LOOP_W'(1);
            skip_total   = '0;
        end
        else
        begin
            status_t got;
            status_t want;
            cmd_fire <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    vpfc_pkg::REG_FRAME_DUR:
                        dur_q8      = cfg_data[vpfc_pkg::DUR_W-1:0];
                    vpfc_pkg::REG_FRAMES_LOOP:
                        frames_loop = cfg_data[vpfc_pkg::FPL_W-1:0];
                    vpfc_pkg::REG_PLAY_LOOPS:
                        loops_cfg   = cfg_data[vpfc_pkg::LOOPS_W-1:0];
                    default: ;
                endcase
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[147:116], m_tdata[115:68], m_tdata[67:37],
                       m_tdata[36:5], m_tdata[4], m_tdata[3], m_tdata[2], m_tdata[1:0]};
                // reorder the flat bus into the struct layout
                got.status    = m_tdata[1:0];
                got.frame_chg = m_tdata[2];
                got.loop_chg  = m_tdata[3];
                got.fin       = m_tdata[4];
                got.frame_num = m_tdata[36:5];
                got.loop_num  = m_tdata[67:37];
                got.loop_ms   = m_tdata[115:68];
                got.skipped   = m_tdata[147:116];
                if (status_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got.status != want.status)
                        $display("%0t: play_status expected %0d got %0d",
                                 $time, want.status, got.status);
                    if (got.frame_chg != want.frame_chg)
                        $display("%0t: frame change flag expected %0d got %0d",
                                 $time, want.frame_chg, got.frame_chg);
                    if (got.loop_chg != want.loop_chg)
                        $display("%0t: loop change flag expected %0d got %0d",
                                 $time, want.loop_chg, got.loop_chg);
                    if (got.fin != want.fin)
                        $display("%0t: finished expected %0d got %0d",
                                 $time, want.fin, got.fin);
                    if (got.frame_num != want.frame_num)
                        $display("%0t: frame_index expected %0d got %0d",
                                 $time, want.frame_num, got.frame_num);
                    if (got.loop_num != want.loop_num)
                        $display("%0t: loop_number expected %0d got %0d",
                                 $time, want.loop_num, got.loop_num);
                    if (got.loop_ms != want.loop_ms)
                        $display("%0t: time within loop expected %0d got %0d",
                                 $time, want.loop_ms, got.loop_ms);
                    if (got.skipped != want.skipped)
                        $display("%0t: skipped_count expected %0d got %0d",
                                 $time, want.skipped, got.skipped);
                    if (got != want)
                        failed = 1'b1;
                end
            end
            if (s_tvalid && s_tready)
                status_due.push_back(play_step('{cmd: s_tuser, ts: s_tdata}));
        end
    end

    task automatic push_cmd(logic [vpfc_pkg::CMD_W-1:0] c, logic [TW-1:0] t);
        pending_cmds.push_back('{cmd: c, ts: t});
    endtask

    // Hold until every queued command is through and every result is back,
    // then let the block settle before touching the registers.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || s_tvalid || status_due.size() != 0);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [vpfc_pkg::IDX_W-1:0] idx,
                             logic [vpfc_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TW-1:0] rand_ts();
        return TW'({$urandom, $urandom});
    endfunction

    // One well-formed playback session with random content and some noise.
    task automatic random_session(int n);
        logic [TW-1:0] t;
        logic [vpfc_pkg::DUR_W:0] step;
        int r;
        t    = ($urandom_range(0, 3) == 0) ? rand_ts() : TW'($urandom);
        step = (dur_q8 == 0) ? 25'd50 : 25'(dur_q8 >> 8) + 25'd1;
        push_cmd(vpfc_pkg::CMD_START, t);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                t = t + TW'($urandom_range(0, 3) * step) + TW'($urandom_range(0, 40));
                push_cmd(vpfc_pkg::CMD_TICK, t);
            end
            else if (r < 75)
            begin
                t = t + TW'($urandom_range(0, 200));
                push_cmd(vpfc_pkg::CMD_PAUSE, t);
            end
            else if (r < 85)
            begin
                t = t + TW'($urandom_range(0, 500));
                push_cmd(vpfc_pkg::CMD_RESUME, t);
            end
            else if (r < 89)
                push_cmd(vpfc_pkg::CMD_TICK, t - TW'($urandom_range(0, 5000)));
            else if (r < 92)
                push_cmd(vpfc_pkg::CMD_STOP, t);
            else if (r < 95)
                push_cmd(vpfc_pkg::CMD_START, t);
            else if (r < 97)
                push_cmd(vpfc_pkg::CMD_TICK, rand_ts());
            else
                push_cmd(vpfc_pkg::CMD_W'($urandom_range(5, 7)), rand_ts());
        end
    endtask

    initial
    begin
        logic [vpfc_pkg::LOOPS_W-1:0] lp;
        logic [31:0]                  fpl;
        logic [vpfc_pkg::DUR_W-1:0]   dur;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        failed    = 1'b0;
        no_gaps   = 1'b0;
        hold_go   = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset values first (no frames, so ticks do nothing)
        push_cmd(vpfc_pkg::CMD_TICK, 48'd5);
        push_cmd(vpfc_pkg::CMD_START, 48'd0);
        push_cmd(vpfc_pkg::CMD_TICK, 48'd100);
        drain();

        // 10 frames of 50 ms (zero duration), two loops
        write_reg(vpfc_pkg::REG_FRAME_DUR, 32'd0);
        write_reg(vpfc_pkg::REG_FRAMES_LOOP, 32'd10);
        write_reg(vpfc_pkg::REG_PLAY_LOOPS, 32'd2);
        push_cmd(vpfc_pkg::CMD_TICK, 48'd1000);       // stopped: no effect
        push_cmd(vpfc_pkg::CMD_RESUME, 48'd1000);     // not paused: ignored
        push_cmd(vpfc_pkg::CMD_START, 48'd1000);
        push_cmd(vpfc_pkg::CMD_TICK, 48'd900);        // before start: elapsed clamps to zero
        push_cmd(vpfc_pkg::CMD_TICK, 48'd1060);
        push_cmd(vpfc_pkg::CMD_TICK, 48'd1260);       // skips frames
        push_cmd(vpfc_pkg::CMD_PAUSE, 48'd1300);
        push_cmd(vpfc_pkg::CMD_PAUSE, 48'd1310);      // already paused
        push_cmd(vpfc_pkg::CMD_TICK, 48'd1320);       // paused: no effect
        push_cmd(vpfc_pkg::CMD_RESUME, 48'd1250);     // time ran backwards
        push_cmd(vpfc_pkg::CMD_PAUSE, 48'd1400);
        push_cmd(vpfc_pkg::CMD_RESUME, 48'd1600);
        push_cmd(vpfc_pkg::CMD_TICK, 48'd1900);       // second loop
        push_cmd(vpfc_pkg::CMD_TICK, 48'd9000);       // finished
        push_cmd(vpfc_pkg::CMD_TICK, 48'd9100);
        push_cmd(vpfc_pkg::CMD_STOP, 48'd9200);
        push_cmd(vpfc_pkg::CMD_STOP, 48'd9300);       // already stopped
        push_cmd(3'd5, TMAX);
        push_cmd(3'd6, 48'd0);
        push_cmd(3'd7, 48'hAAAA_5555_AAAA);
        drain();

        // endless, one-frame loops, shortest duration: loop number saturates
        write_reg(vpfc_pkg::REG_FRAME_DUR, 32'd1);
        write_reg(vpfc_pkg::REG_FRAMES_LOOP, 32'd1);
        write_reg(vpfc_pkg::REG_PLAY_LOOPS, 32'h1FFFF);
        push_cmd(vpfc_pkg::CMD_START, 48'd0);
        push_cmd(vpfc_pkg::CMD_PAUSE, 48'd1);
        push_cmd(vpfc_pkg::CMD_RESUME, TMAX);
        push_cmd(vpfc_pkg::CMD_PAUSE, 48'd0);
        push_cmd(vpfc_pkg::CMD_RESUME, TMAX);          // pause total saturates
        push_cmd(vpfc_pkg::CMD_TICK, TMAX);
        push_cmd(vpfc_pkg::CMD_START, 48'd0);
        push_cmd(vpfc_pkg::CMD_TICK, TMAX);
        drain();

        // widest registers, then most-negative loop count
        write_reg(vpfc_pkg::REG_FRAME_DUR, 32'hFF_FFFF);
        write_reg(vpfc_pkg::REG_FRAMES_LOOP, 32'hFFFF_FFFF);
        write_reg(vpfc_pkg::REG_PLAY_LOOPS, 32'h0FFFF);
        push_cmd(vpfc_pkg::CMD_START, TMAX - 48'd10);
        push_cmd(vpfc_pkg::CMD_TICK, TMAX);
        push_cmd(vpfc_pkg::CMD_START, 48'd0);
        push_cmd(vpfc_pkg::CMD_TICK, TMAX);
        drain();
        write_reg(vpfc_pkg::REG_PLAY_LOOPS, 32'h10000);
        write_reg(vpfc_pkg::REG_FRAME_DUR, 32'd256);
        write_reg(vpfc_pkg::REG_FRAMES_LOOP, 32'd3);
        push_cmd(vpfc_pkg::CMD_START, 48'd0);
        push_cmd(vpfc_pkg::CMD_TICK, 48'd2);
        push_cmd(vpfc_pkg::CMD_TICK, 48'd3);
        push_cmd(vpfc_pkg::CMD_TICK, 48'd4);
        drain();

        // random phases under varied settings
        for (int ph = 0; ph < 16; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       dur = 24'd0;
                1:       dur = 24'hFF_FFFF;
                2:       dur = 24'd1;
                default: dur = vpfc_pkg::DUR_W'($urandom_range(64, 40 * 256));
            endcase
            case ($urandom_range(0, 5))
                0:       fpl = 32'd0;
                1:       fpl = 32'hFFFF_FFFF;
                2:       fpl = 32'd1;
                default: fpl = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       lp = 17'h1FFFF;
                1:       lp = 17'h0FFFF;
                2:       lp = 17'h10000 | vpfc_pkg::LOOPS_W'($urandom);
                3:       lp = 17'd0;
                default: lp = vpfc_pkg::LOOPS_W'($urandom_range(1, 4));
            endcase
            write_reg(vpfc_pkg::REG_FRAME_DUR, {8'd0, dur});
            write_reg(vpfc_pkg::REG_FRAMES_LOOP, fpl);
            write_reg(vpfc_pkg::REG_PLAY_LOOPS, {15'd0, lp});
            no_gaps = (ph % 4 == 1);
            for (int s = 0; s < 3; s++)
                random_session($urandom_range(12, 22));
            // stall the receiver for a long stretch while commands keep coming
            if (ph == 5)
                hold_go++;
            drain();
        end

        drain();
        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
